FILE: rtl/core/bdei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdei_pkg
// Shared sizes, codes and types for the binary despeckle / edge / infill core.
// ----------------------------------------------------------------------------
package bdei_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int ALPHA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = CFG_IDX_W'(1);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(1024);
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(1024);

  // one column of both line stores, two rows each, kept by row parity
  typedef struct packed {
    logic [1:0] raw;
    logic [1:0] clean;
  } line_word_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_word_t       data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr_mid;
    logic [COL_W-1:0] addr_right;
  } mem_rd_t;

endpackage

FILE: rtl/core/bdei_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdei_line_mem
// Column memory for the raw and cleaned line stores: one write port, two
// registered read ports with write-first forwarding.
// ----------------------------------------------------------------------------
module bdei_line_mem
  import bdei_pkg::*;
(
  input  logic       clk,
  input  mem_wr_t    wr,
  input  mem_rd_t    rd,
  output line_word_t rd_mid,
  output line_word_t rd_right
);

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_mid_r;
  line_word_t rd_right_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // a column written on the same edge is passed straight through
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (wr.en && (wr.addr == rd.addr_mid)) begin
        rd_mid_r <= wr.data;
      end else begin
        rd_mid_r <= mem[rd.addr_mid];
      end
      if (wr.en && (wr.addr == rd.addr_right)) begin
        rd_right_r <= wr.data;
      end else begin
        rd_right_r <= mem[rd.addr_right];
      end
    end
  end

  assign rd_mid   = rd_mid_r;
  assign rd_right = rd_right_r;

endmodule

FILE: rtl/core/binary_despeckle_edge_infill_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_despeckle_edge_infill_core
// Raster-order despeckle of an alpha mask, then edge and infill maps of the
// cleaned mask; results trail the input stream by two rows.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            word
//  in_      in   in_valid/in_ready    req_type, pixel_alpha
//  out_     out  out_valid/out_ready  col, row, cleaned, edge, infill, last
//  cfg_     in   cfg_valid/cfg_ready  index, wdata (cfg_ready tied high)
//
// One word per clock while the output is not held. An accepted word is registered
// into the compute stage, where the line memory read issued at accept is available,
// and its result (rows two and up) is then registered into the output register.
// A held output register stalls the compute stage, which drops in_ready.
// Reset clears the position counters and loads the register defaults; the
// line memory is not cleared, rows above the frame are masked by position.
// ----------------------------------------------------------------------------
module binary_despeckle_edge_infill_core
  import bdei_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [ALPHA_W-1:0]    in_pixel_alpha,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COL_W-1:0]      out_col,
  output logic [OUT_ROW_W-1:0]  out_row,
  output logic                  out_cleaned_bit,
  output logic                  out_edge_bit,
  output logic                  out_infill_bit,
  output logic                  out_frame_last,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef struct packed {
    logic                 proc;
    logic                 res;
    logic                 ge1;
    logic                 ge3;
    logic                 mid_in;
    logic                 slot;
    logic                 pix;
    logic                 first_col;
    logic                 last_col;
    logic                 frame_last;
    logic [COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0] orow;
  } stage_t;

  // configuration
  logic [CFG_W_W-1:0] img_width_r;
  logic [CFG_H_W-1:0] img_height_r;
  logic [CFG_W_W-1:0] w_eff;
  logic [CFG_H_W-1:0] h_eff;

  // input position
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CFG_W_W-1:0] col_inc;
  logic [ROW_W:0]     row_ext, row_inc, h_p2;

  logic       in_acc;
  stage_t     stg_in;
  stage_t     b_ctl_r;
  logic       b_valid_r, b_valid_nxt;
  logic       b_leave;
  line_word_t left_r;

  mem_wr_t    mem_wr;
  mem_rd_t    mem_rd;
  line_word_t rd_mid;
  line_word_t rd_right;

  // compute stage
  logic       raw_up2, raw_mid, raw_l, raw_r;
  logic [2:0] cnt;
  logic       cl_new;
  logic       ctr, up_c, lf_c, rt_c;
  logic       edge_b, fill_b;
  line_word_t wr_word;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [COL_W-1:0]     out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic                 out_cleaned_r, out_edge_r, out_infill_r, out_last_r;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= WIDTH_RESET;
      img_height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMG_WIDTH:  img_width_r  <= cfg_wdata[CFG_W_W-1:0];
        REG_IMG_HEIGHT: img_height_r <= cfg_wdata[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_width_r == '0) begin
      w_eff = CFG_W_W'(1);
    end else if (img_width_r > CFG_W_W'(MAX_WIDTH)) begin
      w_eff = CFG_W_W'(MAX_WIDTH);
    end else begin
      w_eff = img_width_r;
    end
    if (img_height_r == '0) begin
      h_eff = CFG_H_W'(1);
    end else if (img_height_r > CFG_H_W'(MAX_HEIGHT)) begin
      h_eff = CFG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_height_r;
    end
  end

  // position and per-word flags, all known at accept
  always_comb begin
    col_inc = CFG_W_W'(col_r) + CFG_W_W'(1);
    row_ext = (ROW_W+1)'(row_r);
    row_inc = row_ext + (ROW_W+1)'(1);
    h_p2    = (ROW_W+1)'(h_eff) + (ROW_W+1)'(2);

    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_p2) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = (row_ext >= h_p2) ? '0 : row_r;
    end

    stg_in.proc       = (CFG_W_W'(col_r) < w_eff) && (row_ext < h_p2);
    stg_in.res        = stg_in.proc && (row_r >= ROW_W'(2));
    stg_in.ge1        = (row_r != '0);
    stg_in.ge3        = (row_r >= ROW_W'(3));
    stg_in.mid_in     = row_ext < ((ROW_W+1)'(h_eff) + (ROW_W+1)'(1));
    stg_in.slot       = row_r[0];
    stg_in.pix        = ((ROW_W+1)'(h_eff) > row_ext) && (in_req_type == REQ_PIXEL) &&
                        (in_pixel_alpha != '0);
    stg_in.first_col  = (col_r == '0);
    stg_in.last_col   = (col_inc >= w_eff);
    stg_in.frame_last = (row_inc == h_p2) && (col_inc == w_eff);
    stg_in.col        = col_r;
    stg_in.orow       = OUT_ROW_W'(row_r - ROW_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // memory reads for the mid and right columns go out at accept
  assign mem_rd.en         = in_acc;
  assign mem_rd.addr_mid   = col_r;
  assign mem_rd.addr_right = col_r + COL_W'(1);

  bdei_line_mem u_line_mem (
    .clk      (clk),
    .wr       (mem_wr),
    .rd       (mem_rd),
    .rd_mid   (rd_mid),
    .rd_right (rd_right)
  );

  assign b_leave  = b_valid_r && (!b_ctl_r.res || !out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_leave;

  always_comb begin
    if (in_acc) begin
      b_valid_nxt = 1'b1;
    end else if (b_leave) begin
      b_valid_nxt = 1'b0;
    end else begin
      b_valid_nxt = b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  // left column is the previous word's mid read, still held in the memory output
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_ctl_r <= stg_in;
      left_r  <= rd_mid;
    end
  end

  // despeckle of row r-1, then edge / infill of row r-2
  always_comb begin
    raw_up2 = b_ctl_r.res && rd_mid.raw[b_ctl_r.slot];
    raw_mid = b_ctl_r.ge1 && rd_mid.raw[~b_ctl_r.slot];
    raw_l   = b_ctl_r.ge1 && !b_ctl_r.first_col && left_r.raw[~b_ctl_r.slot];
    raw_r   = b_ctl_r.ge1 && !b_ctl_r.last_col && rd_right.raw[~b_ctl_r.slot];
    cnt     = 3'(raw_up2) + 3'(b_ctl_r.pix) + 3'(raw_l) + 3'(raw_r);
    cl_new  = b_ctl_r.ge1 && b_ctl_r.mid_in && raw_mid && (cnt > 3'd1);

    ctr     = rd_mid.clean[b_ctl_r.slot];
    up_c    = b_ctl_r.ge3 && rd_mid.clean[~b_ctl_r.slot];
    lf_c    = !b_ctl_r.first_col && left_r.clean[b_ctl_r.slot];
    rt_c    = !b_ctl_r.last_col && rd_right.clean[b_ctl_r.slot];
    edge_b  = ctr && !(up_c && cl_new && lf_c && rt_c);
    fill_b  = ctr && !edge_b;

    wr_word = rd_mid;
    wr_word.raw[b_ctl_r.slot] = b_ctl_r.pix;
    if (b_ctl_r.ge1) begin
      wr_word.clean[~b_ctl_r.slot] = cl_new;
    end
  end

  assign mem_wr.en   = b_leave && b_ctl_r.proc;
  assign mem_wr.addr = b_ctl_r.col;
  assign mem_wr.data = wr_word;

  assign out_load = b_leave && b_ctl_r.res;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col_r     <= b_ctl_r.col;
      out_row_r     <= b_ctl_r.orow;
      out_cleaned_r <= ctr;
      out_edge_r    <= edge_b;
      out_infill_r  <= fill_b;
      out_last_r    <= b_ctl_r.frame_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_col         = out_col_r;
  assign out_row         = out_row_r;
  assign out_cleaned_bit = out_cleaned_r;
  assign out_edge_bit    = out_edge_r;
  assign out_infill_bit  = out_infill_r;
  assign out_frame_last  = out_last_r;

  a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> b_valid_r)
    else $error("accepted word did not reach the compute stage");

  a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_ctl_r.res && out_valid_r && !out_ready) |=>
      (b_valid_r && $stable(b_ctl_r)))
    else $error("pending result left the compute stage during an output stall");

  a_map_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_cleaned_r == (out_edge_r || out_infill_r)) &&
                     !(out_edge_r && out_infill_r)))
    else $error("edge and infill bits disagree with the cleaned bit");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_despeckle_edge_infill_core. A queue-fed
// driver streams raster frames (directed corner cases, clamped frame sizes,
// then random frames with idle cycles and misplaced item types) while a
// monitor runs a bit-accurate despeckle / edge / infill predictor on every
// accepted word and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bdei_pkg::*;

  localparam int IDLE_PCT      = 7;
  localparam int RANDOM_ITEMS  = 950;
  localparam int SETTLE_CYCLES = 6;
  localparam int RAW_LINE      = 0;
  localparam int CLEAN_LINE    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    logic               req_type;
    logic [ALPHA_W-1:0] alpha;
  } pixel_word_t;

  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic [OUT_ROW_W-1:0] row;
    logic                 cleaned;
    logic                 edge_bit;
    logic                 infill;
    logic                 frame_last;
  } mask_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_PIXEL;
  logic [ALPHA_W-1:0]    in_pixel_alpha = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COL_W-1:0]      out_col;
  logic [OUT_ROW_W-1:0]  out_row;
  logic                  out_cleaned_bit;
  logic                  out_edge_bit;
  logic                  out_infill_bit;
  logic                  out_frame_last;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pixel_word_t  pixel_q[$];
  mask_result_t mask_q[$];

  logic in_fired = 1'b0;
  bit   quiet = 1'b0;
  bit   hold_input = 1'b0;
  int   error_count = 0;

  // predictor state
  logic [CFG_W_W-1:0] width_reg;
  logic [CFG_H_W-1:0] height_reg;
  bit line_mem [2][2][MAX_WIDTH];
  int pos_col;
  int pos_row;

  binary_despeckle_edge_infill_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_pixel_alpha  (in_pixel_alpha),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_cleaned_bit (out_cleaned_bit),
    .out_edge_bit    (out_edge_bit),
    .out_infill_bit  (out_infill_bit),
    .out_frame_last  (out_frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int frame_width();
    int w;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int frame_height();
    int h;
    h = int'(height_reg);
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // columns outside the row read as unset
  function automatic bit line_bit(int kind, int slot, int col, int w);
    if (col < 0 || col >= w) return 1'b0;
    return line_mem[kind][slot & 1][col];
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic void despeckle_step(logic req, logic [ALPHA_W-1:0] alpha);
    int w, h, r, c, cnt;
    bit pix, up2, mid, raw_lf, raw_rt, cl_new, ctr, up, lf, rt, is_edge;
    mask_result_t res;
    w = frame_width();
    h = frame_height();
    r = pos_row;
    c = pos_col;
    if (c < w && r < h + 2) begin
      pix = (r < h && req == REQ_PIXEL && alpha != '0);
      // row r-2 still sits in the slot row r is about to overwrite
      up2 = (r >= 2) ? line_bit(RAW_LINE, r, c, w) : 1'b0;
      cl_new = 1'b0;
      if (r >= 1) begin
        mid = line_bit(RAW_LINE, r - 1, c, w);
        raw_lf = line_bit(RAW_LINE, r - 1, c - 1, w);
        raw_rt = line_bit(RAW_LINE, r - 1, c + 1, w);
        if (r - 1 < h) begin
          cnt = int'(up2) + int'(pix) + int'(raw_lf) + int'(raw_rt);
          cl_new = mid && cnt > 1;
        end
      end
      line_mem[RAW_LINE][r & 1][c] = pix;
      if (r >= 2) begin
        ctr = line_bit(CLEAN_LINE, r, c, w);
        up = (r >= 3) ? line_bit(CLEAN_LINE, r - 1, c, w) : 1'b0;
        lf = line_bit(CLEAN_LINE, r, c - 1, w);
        rt = line_bit(CLEAN_LINE, r, c + 1, w);
        is_edge = ctr && !(up && cl_new && lf && rt);
        res.col = c[COL_W-1:0];
        res.row = OUT_ROW_W'(r - 2);
        res.cleaned = ctr;
        res.edge_bit = is_edge;
        res.infill = ctr && !is_edge;
        res.frame_last = (r - 2 == h - 1 && c == w - 1);
        mask_q.push_back(res);
      end
      if (r >= 1) line_mem[CLEAN_LINE][(r - 1) & 1][c] = cl_new;
    end
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h + 2) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
      if (r >= h + 2) pos_row = 0;
    end
  endfunction

  // monitor: accepted pixels, register writes and result words
  always @(posedge clk) begin
    mask_result_t want;
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      pos_col = 0;
      pos_row = 0;
      line_mem = '{default: 1'b0};
    end else begin
      // a word taken on a write edge still sees the old size
      if (in_valid && in_ready) despeckle_step(in_req_type, in_pixel_alpha);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMG_WIDTH: begin
            width_reg = cfg_wdata[CFG_W_W-1:0];
          end
          REG_IMG_HEIGHT: begin
            height_reg = cfg_wdata[CFG_H_W-1:0];
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (mask_q.size() == 0) begin
          flag_error($sformatf("unexpected word col %0d row %0d", out_col, out_row));
        end else begin
          want = mask_q.pop_front();
          check_field("col", int'(out_col), int'(want.col));
          check_field("row", int'(out_row), int'(want.row));
          check_field("cleaned", int'(out_cleaned_bit), int'(want.cleaned));
          check_field("edge", int'(out_edge_bit), int'(want.edge_bit));
          check_field("infill", int'(out_infill_bit), int'(want.infill));
          check_field("frame_last", int'(out_frame_last), int'(want.frame_last));
        end
      end
    end
    in_fired <= rst_n && in_valid && in_ready;
  end

  // driver: next word once the current one is taken
  always @(negedge clk) begin
    pixel_word_t word;
    if (rst_n && (!in_valid || in_fired)) begin
      if (pixel_q.size() != 0 && !hold_input && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        word = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_req_type <= word.req_type;
        in_pixel_alpha <= word.alpha;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic push_word(logic req, logic [ALPHA_W-1:0] alpha);
    pixel_word_t word;
    word.req_type = req;
    word.alpha = alpha;
    pixel_q.push_back(word);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (in_valid || mask_q.size() != 0 || (pixel_q.size() != 0 && !hold_input));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ALPHA_W-1:0] pick_alpha(bit set);
    if (!set) return '0;
    case ($urandom_range(3))
      0: return ALPHA_W'(1) << $urandom_range(ALPHA_W - 1);
      1: return '1;
      default: return ALPHA_W'($urandom_range(65535, 1));
    endcase
  endfunction

  // one whole frame plus its two drain rows at the current size
  task automatic queue_frame(int density, int noise);
    int w, h;
    logic req;
    w = frame_width();
    h = frame_height();
    for (int r = 0; r < h + 2; r++) begin
      for (int c = 0; c < w; c++) begin
        req = (r < h) ? REQ_PIXEL : REQ_DRAIN;
        if ($urandom_range(99) < noise) req = ~req;
        if (req == REQ_DRAIN) push_word(req, ALPHA_W'($urandom()));
        else push_word(req, pick_alpha($urandom_range(99) < density));
      end
    end
  endtask

  initial begin
    int w, h, reps, density, noise, items, phase, half;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x3 frame, one corner unset: corners kept, center is infill;
    // a pixel word in the drain rows must count as unset
    write_reg(REG_SPARE, '1);
    write_reg(REG_IMG_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(3));
    push_word(REQ_PIXEL, 16'hFFFF);
    push_word(REQ_PIXEL, 16'h0001);
    push_word(REQ_PIXEL, 16'h8000);
    push_word(REQ_PIXEL, 16'h1234);
    push_word(REQ_PIXEL, 16'hFFFF);
    push_word(REQ_PIXEL, 16'h0100);
    push_word(REQ_PIXEL, 16'h0000);
    push_word(REQ_PIXEL, 16'h4000);
    push_word(REQ_PIXEL, 16'h0002);
    push_word(REQ_DRAIN, 16'h0000);
    push_word(REQ_PIXEL, 16'hFFFF);
    push_word(REQ_DRAIN, 16'hFFFF);
    repeat (3) push_word(REQ_DRAIN, 16'h0000);
    wait_drained();

    // single row: isolated pixels removed, drain word inside the frame is unset
    write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(1));
    push_word(REQ_PIXEL, 16'hFFFF);
    push_word(REQ_DRAIN, 16'hFFFF);
    push_word(REQ_PIXEL, 16'h0001);
    push_word(REQ_PIXEL, 16'hAAAA);
    push_word(REQ_DRAIN, 16'h5555);
    push_word(REQ_PIXEL, 16'h0000);
    repeat (3) push_word(REQ_DRAIN, 16'h0000);
    wait_drained();

    // a wider frame with no idling, then sizes clamped up from zero
    quiet = 1'b1;
    write_reg(REG_IMG_WIDTH, CFG_DATA_W'(40));
    write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(4));
    queue_frame(70, 0);
    wait_drained();
    quiet = 1'b0;
    write_reg(REG_IMG_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(0));
    queue_frame(55, 3);
    wait_drained();
    write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(6));
    queue_frame(60, 2);
    wait_drained();

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
      h = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : $urandom_range(10, 1);
      reps = $urandom_range(2, 1);
      density = 35 + 27 * $urandom_range(2);
      noise = (phase % 4 == 3) ? 6 : 0;
      quiet = (phase == 2 || phase == 3);
      write_reg(REG_IMG_WIDTH, CFG_DATA_W'(w));
      write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(h));
      for (int i = 0; i < reps; i++) queue_frame(density, noise);
      if (phase == 1) begin
        // stop the sender mid-stream until every result is back
        half = pixel_q.size() / 2;
        while (pixel_q.size() > half) @(posedge clk);
        hold_input = 1'b1;
        wait_drained();
        hold_input = 1'b0;
      end
      wait_drained();
      items += reps * w * (h + 2);
      phase++;
    end

    if (error_count == 0 && mask_q.size() == 0) begin
      $display("binary_despeckle_edge_infill_core verification clean");
    end else begin
      $display("binary_despeckle_edge_infill_core verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("binary_despeckle_edge_infill_core verification failed");
    $finish;
  end

endmodule
